[design/epq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epq_pkg
// Shared types and codes for the event priority queue.
// ----------------------------------------------------------------------------
package epq_pkg;

  localparam logic [1:0] OP_SCHED  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_PAST  = 3'd1;
  localparam logic [2:0] ST_NOKEY = 3'd2;
  localparam logic [2:0] ST_EMPTY = 3'd3;
  localparam logic [2:0] ST_LIMIT = 3'd4;
  localparam logic [2:0] ST_FULL  = 3'd5;

  // number of cancellation keys; a power of two so keys reduce by a mask
  localparam int KEY_COUNT = 256;

  typedef struct packed {
    logic [47:0] etime;
    logic [3:0]  prio;
    logic [31:0] id;
    logic [2:0]  kind;
    logic [31:0] payload;
    logic        kvalid;
    logic [7:0]  key;
    logic [15:0] gen;
  } entry_t;

  function automatic logic earlier(entry_t a, entry_t b);
    if (a.etime != b.etime) return a.etime < b.etime;
    if (a.prio != b.prio) return a.prio < b.prio;
    return a.id < b.id;
  endfunction

endpackage

[design/event_priority_queue_with_cancel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_priority_queue_with_cancel
// Min-heap event queue with key cancellation and same-time pop limit.
// ----------------------------------------------------------------------------
// channel  handshake                 payload
// in       in_valid / in_ready       operation .. payload_ref
// out      out_valid / out_ready     status .. pending_count
// cfg      cfg_we                    cfg_data (same_time_limit)
//
// A schedule sifts the new entry up level by level; a pop removes the top
// and sifts the last entry down, with stale tops each adding one removal,
// and reports empty when no live top remains. All heap work runs through
// the one-read one-write entry memory. Reset is synchronous and clears
// control state and the generation table through valid bits; heap
// contents are not cleared.
// in_ready is low from accept until the result item is taken.
// ----------------------------------------------------------------------------
module event_priority_queue_with_cancel #(
  parameter int CAPACITY  = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [47:0] event_time,
  input  logic [3:0]  priority_req,
  input  logic        has_key,
  input  logic [7:0]  key_index,
  input  logic [2:0]  event_kind,
  input  logic [31:0] payload_ref,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] evt_id,
  output logic [47:0] event_time_res,
  output logic [3:0]  priority_res,
  output logic [2:0]  event_kind_res,
  output logic [31:0] payload_ref_res,
  output logic [15:0] generation,
  output logic        has_key_res,
  output logic [7:0]  key_index_res,
  output logic [47:0] now_time_res,
  output logic [10:0] pending_count,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import epq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_UPRD  = 4'd2;
  localparam logic [3:0] S_UPCMP = 4'd3;
  localparam logic [3:0] S_TOPRD = 4'd4;
  localparam logic [3:0] S_TOPCK = 4'd5;
  localparam logic [3:0] S_LSTRD = 4'd6;
  localparam logic [3:0] S_LRD   = 4'd7;
  localparam logic [3:0] S_LCMP  = 4'd8;
  localparam logic [3:0] S_RCMP  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_GEN   = 4'd12;
  localparam logic [3:0] S_WAIT  = 4'd13;

  logic [3:0] state;
  logic [15:0] limit;
  logic [CW-1:0] cnt;
  logic [31:0] next_id;
  logic [47:0] now_t, last_t;
  logic last_v;
  logic [15:0] same_cnt;

  logic [1:0] op;
  entry_t cur;          // entry being moved
  entry_t top;          // popped event
  entry_t best;
  logic [AW-1:0] pos, bpos;
  logic popping;        // removing a live top (vs stale)

  logic [15:0] gtab [KEY_COUNT];
  logic [KEY_COUNT-1:0] gvalid;
  logic [KW-1:0] key_r;
  logic [15:0] gen_rd;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  epq_heap_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [KW-1:0] key_in;
  assign key_in = key_index[KW-1:0];

  logic [KW-1:0] gaddr;
  always_ff @(posedge clk) begin
    gen_rd <= gvalid[gaddr] ? gtab[gaddr] : 16'd0;
  end

  assign in_ready = (state == S_IDLE);

  logic [AW:0] lch, rch, cnt_x;
  assign lch = {pos, 1'b1};
  assign rch = {pos, 1'b1} + (AW+1)'(1);
  assign cnt_x = (AW+1)'(cnt);

  logic [15:0] same_nx;
  logic same_hit;
  assign same_hit = last_v && (last_t == top.etime);
  assign same_nx = same_hit ? ((same_cnt == 16'hFFFF) ? same_cnt : same_cnt + 16'd1)
                            : 16'd1;

  always_comb begin
    we = 1'b0;
    waddr = pos;
    wdata = cur;
    raddr = pos;
    gaddr = key_r;
    unique case (state)
      S_IDLE:  gaddr = key_in;
      S_UPRD:  raddr = AW'((pos - AW'(1)) >> 1);
      S_TOPRD: raddr = '0;
      S_TOPCK: gaddr = rdata.key[KW-1:0];
      S_LSTRD: raddr = AW'(cnt - CW'(1));
      S_LRD:   raddr = lch[AW-1:0];
      S_LCMP:  raddr = rch[AW-1:0];
      default: ;
    endcase
    if (state == S_UPCMP && !(pos != '0 && earlier(cur, rdata))) we = 1'b1;
    if (state == S_UPCMP && pos != '0 && earlier(cur, rdata)) begin
      we = 1'b1;
      wdata = rdata;
    end
    if (state == S_LRD && lch >= cnt_x) begin
      we = 1'b1;
      if (pos == '0) wdata = rdata;
    end
    if (state == S_RCMP) begin
      we = 1'b1;
      wdata = (rch < cnt_x && earlier(rdata, best)) ? rdata : best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      limit <= 16'd1024;
      cnt <= '0;
      next_id <= '0;
      now_t <= '0;
      last_t <= '0;
      last_v <= 1'b0;
      same_cnt <= '0;
      gvalid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_data;
      unique case (state)
        S_IDLE: if (in_valid) begin
          op <= operation;
          key_r <= key_in;
          cur.etime <= event_time;
          cur.prio <= priority_req;
          cur.id <= next_id;
          cur.kind <= event_kind;
          cur.payload <= payload_ref;
          cur.kvalid <= has_key;
          cur.key <= has_key ? 8'(key_in) : 8'd0;
          status <= ST_OK;
          evt_id <= '0; event_time_res <= '0; priority_res <= '0;
          event_kind_res <= '0; payload_ref_res <= '0; generation <= '0;
          has_key_res <= 1'b0; key_index_res <= '0;
          state <= S_DISP;
        end
        S_DISP: begin
          unique case (op)
            OP_SCHED: begin
              cur.gen <= cur.kvalid ? gen_rd : 16'd0;
              if (cur.etime < now_t) begin
                status <= ST_PAST; state <= S_DONE;
              end else if (cnt >= CW'(CAPACITY)) begin
                status <= ST_FULL; state <= S_DONE;
              end else begin
                evt_id <= next_id;
                generation <= cur.kvalid ? gen_rd : 16'd0;
                has_key_res <= cur.kvalid;
                key_index_res <= cur.key;
                next_id <= next_id + 32'd1;
                pos <= AW'(cnt);
                cnt <= cnt + CW'(1);
                state <= S_UPRD;
              end
            end
            OP_CANCEL: begin
              if (!cur.kvalid) begin
                status <= ST_NOKEY; state <= S_DONE;
              end else state <= S_GEN;
            end
            OP_POP: state <= S_TOPRD;
            default: state <= S_DONE;
          endcase
        end
        S_GEN: begin
          gtab[key_r] <= gen_rd + 16'd1;
          gvalid[key_r] <= 1'b1;
          generation <= gen_rd + 16'd1;
          has_key_res <= 1'b1;
          key_index_res <= 8'(key_r);
          state <= S_DONE;
        end
        S_UPRD: state <= S_UPCMP;
        S_UPCMP: begin
          if (pos != '0 && earlier(cur, rdata)) begin
            pos <= AW'((pos - AW'(1)) >> 1);
            state <= S_UPRD;
          end else state <= S_DONE;
        end
        S_TOPRD: begin
          if (cnt == '0) begin
            status <= ST_EMPTY; state <= S_DONE;
          end else state <= S_TOPCK;
        end
        S_TOPCK: begin
          // rdata holds top; gen_rd valid next cycle
          top <= rdata;
          state <= S_LSTRD;
          popping <= 1'b0;
        end
        S_LSTRD: begin
          if (top.kvalid && gen_rd != top.gen) popping <= 1'b0;
          else begin
            popping <= 1'b1;
            evt_id <= top.id; event_time_res <= top.etime;
            priority_res <= top.prio; event_kind_res <= top.kind;
            payload_ref_res <= top.payload; generation <= top.gen;
            has_key_res <= top.kvalid; key_index_res <= top.key;
            last_v <= 1'b1; last_t <= top.etime; same_cnt <= same_nx;
            if (same_nx > limit) status <= ST_LIMIT;
            else now_t <= top.etime;
          end
          cnt <= cnt - CW'(1);
          pos <= '0;
          state <= S_LRD;
        end
        S_LRD: begin
          // rdata = last entry on first pass, else current already held
          if (pos == '0) cur <= rdata;
          if (lch >= cnt_x) state <= S_OUT;
          else state <= S_LCMP;
        end
        S_LCMP: begin
          best <= earlier(rdata, cur) ? rdata : cur;
          bpos <= earlier(rdata, cur) ? lch[AW-1:0] : pos;
          state <= S_RCMP;
        end
        S_RCMP: begin
          // write winner at pos
          if (rch < cnt_x && earlier(rdata, best)) begin
            pos <= rch[AW-1:0];
            state <= S_LRD;
          end else if (bpos != pos) begin
            pos <= bpos;
            state <= S_LRD;
          end else state <= S_OUT;
        end
        S_OUT: state <= popping ? S_DONE : S_TOPRD;
        S_DONE: begin
          now_time_res <= now_t;
          pending_count <= 11'(cnt);
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        default: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("ready while result pending");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY)) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
endmodule

[design/epq_heap_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epq_heap_mem
// Heap entry storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module epq_heap_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  epq_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output epq_pkg::entry_t rdata
);
  import epq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
